// ===== hdl/rva_pkg.sv =====
// ----------------------------------------------------------------------------
// rva_pkg
// shared constants, widths and helpers for rack voltage arbitration
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int MAX_RACKS = 32;
  localparam int V_W       = 18;
  localparam int T_W       = V_W + 1;
  localparam int CS_W      = 2;
  localparam int IDX_W     = (MAX_RACKS > 1) ? $clog2(MAX_RACKS) : 1;
  localparam int CNT_W     = $clog2(MAX_RACKS + 1);
  localparam int SUM_W     = V_W + CNT_W;
  localparam int STEP_W    = $clog2(SUM_W);

  localparam logic [V_W-1:0]  DEADBAND_RESET = V_W'(100);
  localparam logic [CS_W-1:0] CS_OPEN        = CS_W'(0);
  localparam logic [CS_W-1:0] CS_CLOSED      = CS_W'(1);

  function automatic logic [V_W-1:0] absdiff(input logic [V_W-1:0] a,
                                             input logic [V_W-1:0] b);
    logic [V_W-1:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = b - a;
    end
    return d;
  endfunction

endpackage

// ===== hdl/rack_voltage_arbitration.sv =====
// ----------------------------------------------------------------------------
// rack_voltage_arbitration
// loads racks one per transfer, then scans stored open voltages to pick
// and average a balancing target
// ----------------------------------------------------------------------------
// sequence: a rack without last_rack leaves busy low; after last_rack with n
//   stored open racks: check, two scans of the n racks, pick, 24 divider
//   steps; done from check if nothing to scan, pick if none outside deadband
// throughput: one rack per cycle until last_rack, then busy until done
// result strobe done lasts one cycle and cannot be stalled
// reset: deadband returns to 100, the rack set is empty, no result pending
module rack_voltage_arbitration (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [rva_pkg::V_W-1:0]             rack_voltage,
  input  logic [rva_pkg::CS_W-1:0]            contactor_state,
  input  logic                                last_rack,
  input  logic                                cfg_wr_en,
  input  logic [rva_pkg::V_W-1:0]             cfg_wr_data,
  output logic                                done,
  output logic signed [rva_pkg::T_W-1:0]      target_voltage,
  output logic                                balancing_needed,
  output logic                                no_closed_rack
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RANGE,
    ST_PICK,
    ST_SCAN_AVG,
    ST_DIVIDE
  } state_t;

  state_t                        state;
  logic [rva_pkg::V_W-1:0]       deadband;
  logic [rva_pkg::V_W-1:0]       mem [rva_pkg::MAX_RACKS];
  logic [rva_pkg::V_W-1:0]       rd_data;
  logic                          rd_valid;
  logic [rva_pkg::CNT_W-1:0]     open_count;
  logic [rva_pkg::V_W-1:0]       reference_voltage;
  logic                          reference_seen;
  logic [rva_pkg::CNT_W-1:0]     idx;
  logic                          any_far;
  logic [rva_pkg::V_W-1:0]       lo;
  logic [rva_pkg::V_W-1:0]       hi;
  logic [rva_pkg::V_W-1:0]       best;
  logic [rva_pkg::SUM_W-1:0]     sum;
  logic [rva_pkg::CNT_W-1:0]     cnt;
  logic [rva_pkg::CNT_W-1:0]     rem;
  logic [rva_pkg::STEP_W-1:0]    step;

  logic                          accept;
  logic                          store_wr;
  logic                          scanning;
  logic                          rd_en;
  logic                          far;
  logic                          near_best;
  logic [rva_pkg::CNT_W:0]       rem_shift;
  logic                          q_bit;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign store_wr = accept && (contactor_state == rva_pkg::CS_OPEN) &&
                    (open_count < rva_pkg::CNT_W'(rva_pkg::MAX_RACKS));
  assign scanning = (state == ST_SCAN_RANGE) || (state == ST_SCAN_AVG);
  assign rd_en    = scanning && (idx < open_count);

  assign far       = rva_pkg::absdiff(rd_data, reference_voltage) >= deadband;
  assign near_best = rva_pkg::absdiff(rd_data, best) <= deadband;

  assign rem_shift = {rem, sum[rva_pkg::SUM_W-1]};
  assign q_bit     = rem_shift >= {1'b0, cnt};

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[open_count[rva_pkg::IDX_W-1:0]] <= rack_voltage;
    end
    if (rd_en) begin
      rd_data <= mem[idx[rva_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      deadband          <= rva_pkg::DEADBAND_RESET;
      open_count        <= '0;
      reference_voltage <= '0;
      reference_seen    <= 1'b0;
      rd_valid          <= 1'b0;
      done              <= 1'b0;
      idx               <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= rd_en;
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (cfg_wr_en) begin
        deadband <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (contactor_state == rva_pkg::CS_CLOSED && !reference_seen) begin
              reference_voltage <= rack_voltage;
              reference_seen    <= 1'b1;
            end else if (store_wr) begin
              open_count <= open_count + 1'b1;
            end
            if (last_rack) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          idx     <= '0;
          any_far <= 1'b0;
          if (open_count == '0 || !reference_seen) begin
            done              <= 1'b1;
            target_voltage    <= '1;
            balancing_needed  <= 1'b0;
            no_closed_rack    <= (open_count != '0);
            open_count        <= '0;
            reference_voltage <= '0;
            reference_seen    <= 1'b0;
            state             <= ST_IDLE;
          end else begin
            state <= ST_SCAN_RANGE;
          end
        end
        ST_SCAN_RANGE: begin
          if (rd_valid && far) begin
            if (!any_far || rd_data < lo) begin
              lo <= rd_data;
            end
            if (!any_far || rd_data > hi) begin
              hi <= rd_data;
            end
            any_far <= 1'b1;
          end
          if (!rd_en && !rd_valid) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          idx <= '0;
          sum <= '0;
          cnt <= '0;
          if (!any_far) begin
            done              <= 1'b1;
            target_voltage    <= '1;
            balancing_needed  <= 1'b0;
            no_closed_rack    <= 1'b0;
            open_count        <= '0;
            reference_voltage <= '0;
            reference_seen    <= 1'b0;
            state             <= ST_IDLE;
          end else begin
            if (rva_pkg::absdiff(lo, reference_voltage) <=
                rva_pkg::absdiff(hi, reference_voltage)) begin
              best <= lo;
            end else begin
              best <= hi;
            end
            state <= ST_SCAN_AVG;
          end
        end
        ST_SCAN_AVG: begin
          if (rd_valid && far && near_best) begin
            sum <= sum + rva_pkg::SUM_W'(rd_data);
            cnt <= cnt + 1'b1;
          end
          if (!rd_en && !rd_valid) begin
            rem   <= '0;
            step  <= '0;
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (q_bit) begin
            rem <= rva_pkg::CNT_W'(rem_shift - {1'b0, cnt});
          end else begin
            rem <= rem_shift[rva_pkg::CNT_W-1:0];
          end
          sum  <= {sum[rva_pkg::SUM_W-2:0], q_bit};
          step <= step + 1'b1;
          if (step == rva_pkg::STEP_W'(rva_pkg::SUM_W - 1)) begin
            done              <= 1'b1;
            target_voltage    <= $signed({1'b0, sum[rva_pkg::V_W-2:0], q_bit});
            balancing_needed  <= 1'b1;
            no_closed_rack    <= 1'b0;
            open_count        <= '0;
            reference_voltage <= '0;
            reference_seen    <= 1'b0;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a pending set");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(balancing_needed && no_closed_rack))
    else $error("balancing and missing reference both flagged");

  a_no_balance_target: assert property (@(posedge clk) disable iff (rst)
    (done && !balancing_needed) |-> (target_voltage == -1))
    else $error("target not -1 without balancing");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= rva_pkg::CNT_W'(rva_pkg::MAX_RACKS))
    else $error("open count beyond store depth");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (open_count == '0 && !reference_seen))
    else $error("set state not cleared after result");

endmodule
